// ----- hdl/rtp_h264_nal_packetizer_assert.svh -----
// Assertion macros for the checker file of the RTP H.264 packetizer.
`ifndef RTP_H264_NAL_PACKETIZER_ASSERT_SVH
`define RTP_H264_NAL_PACKETIZER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RTPNAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define RTPNAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/rtpnal_pkg.sv -----
// Package with the payload types and constants of the RTP H.264 packetizer.
`default_nettype none

package rtpnal_pkg;

  // One NAL byte as it enters the block.
  typedef struct packed {
    logic [7:0]  nal_byte;
    logic        nal_first;
    logic [23:0] nal_length;
    logic [31:0] frame_timestamp;
  } nal_item_t;

  // One RTP packet byte as it leaves the block.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] packet_bytes;
    logic        nal_done;
    logic        run_last;
  } pkt_item_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_PAYLOAD_TYPE = 2'd0;
  localparam logic [1:0] REG_MTU_BYTES    = 2'd1;
  localparam logic [1:0] REG_STREAM_SSRC  = 2'd2;
  localparam logic [1:0] REG_SEQ_START    = 2'd3;

  // Protocol constants.
  localparam logic [7:0]  RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0]  NAL_NRI_MASK     = 8'hE0;
  localparam logic [7:0]  NAL_TYPE_MASK    = 8'h1F;
  localparam logic [7:0]  FU_A_TYPE        = 8'd28;
  localparam logic [7:0]  FU_START_BIT     = 8'h80;
  localparam logic [7:0]  FU_END_BIT       = 8'h40;
  localparam logic [15:0] RTP_HDR_BYTES    = 16'd12;
  localparam logic [15:0] FU_PKT_OVERHEAD  = 16'd14;
  localparam logic [15:0] FU_MTU_MIN       = 16'd15;

  // Reset values of the configuration.
  localparam logic [6:0]  PAYLOAD_TYPE_RST = 7'd96;
  localparam logic [15:0] MTU_BYTES_RST    = 16'd1400;

  // Byte positions inside an output burst.
  localparam logic [3:0] POS_FIRST   = 4'd0;
  localparam logic [3:0] POS_FU_IND  = 4'd12;
  localparam logic [3:0] POS_FU_HDR  = 4'd13;
  localparam logic [3:0] POS_PAYLOAD = 4'd14;

endpackage

`default_nettype wire

// ----- hdl/rtp_h264_nal_packetizer.sv -----
// Usage: NAL bytes enter on the nal channel, RTP packet bytes leave on pkt.
// Each nal transaction carries one NAL byte; the first byte of a unit has
// nal_first set together with the unit length and the RTP timestamp.
// The cfg channel writes payload_type, mtu_bytes, stream_ssrc and seq_start
// by index; write it only while the block is idle. cfg_ready is always high.
// The first result of a byte passes the burst stage and then the output
// register before it appears on pkt. A payload byte passes at one per cycle
// while the receiver does not stall. A byte that opens an RTP packet yields
// a header burst: 13 results for a single NAL unit packet, 15 for an FU-A
// fragment, and nal_ready stays low until the burst's last result is moved
// into the output register. Bytes that cause no result (dropped units, stray
// bytes, the NAL header of a fragmented unit) load no burst.
// Reset clears pkt_valid and the burst stage, restores the register
// defaults and sets the sequence number to zero.
// When the receiver stalls, the output register holds its transaction and
// the burst stage holds the next one, so nal_ready drops after one stage.
`default_nettype none

module rtp_h264_nal_packetizer
  import rtpnal_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        nal_valid,
  output logic             nal_ready,
  input  wire nal_item_t   nal,
  output logic             pkt_valid,
  input  wire logic        pkt_ready,
  output pkt_item_t        pkt,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  // Configuration registers; the mtu is kept as its two derived limits.
  logic [6:0]  payload_type;
  logic [31:0] stream_ssrc;
  logic [15:0] single_max;
  logic [15:0] frag_max;

  // Packetizer state.
  logic [15:0] seq_counter;
  logic [7:0]  saved_nal_header;
  logic [31:0] latched_timestamp;
  logic [23:0] bytes_remaining;
  logic [15:0] fragment_left;
  logic        fragment_mode;
  logic        first_fragment;
  logic        drop_unit;
  logic [15:0] pkt_size;
  logic        pkt_final;

  // Burst stage: one accepted byte and the header it opens.
  logic        burst_valid;
  logic [3:0]  burst_pos;
  logic [3:0]  burst_end;
  logic        burst_frag;
  logic        burst_marker;
  logic        burst_last;
  logic [15:0] burst_seq;
  logic [31:0] burst_ts;
  logic [7:0]  burst_fu_ind;
  logic [7:0]  burst_fu_hdr;
  logic [7:0]  burst_data;
  logic [15:0] burst_size;
  logic        burst_final;

  logic nal_fire;
  logic cfg_fire;
  logic advance;
  logic burst_done;

  assign cfg_ready  = 1'b1;
  assign cfg_fire   = cfg_valid & cfg_ready;
  assign advance    = burst_valid & (~pkt_valid | pkt_ready);
  assign burst_done = advance & (burst_pos == burst_end);
  assign nal_ready  = ~burst_valid | burst_done;
  assign nal_fire   = nal_valid & nal_ready;

  // Per-byte decisions, all taken from the state before this transaction.
  logic        load_burst;
  logic        load_frag;
  logic        load_marker;
  logic        seg_last;
  logic [3:0]  load_pos;
  logic [3:0]  load_end;
  logic [15:0] frag_size;
  logic        frag_end;
  logic [15:0] frag_left_eff;
  logic [15:0] size_next;
  logic        final_next;
  logic        first_len_ok;
  logic        first_is_frag;

  always_comb begin
    first_len_ok  = nal.nal_length >= 24'd2;
    first_is_frag = nal.nal_length > {8'd0, single_max};
    frag_end      = bytes_remaining <= {8'd0, frag_max};
    frag_size     = frag_end ? bytes_remaining[15:0] : frag_max;
    frag_left_eff = fragment_left;
    load_burst    = 1'b0;
    load_frag     = 1'b0;
    load_marker   = 1'b0;
    seg_last      = 1'b0;
    load_pos      = POS_PAYLOAD;
    load_end      = POS_PAYLOAD;
    size_next     = pkt_size;
    final_next    = pkt_final;
    if (nal.nal_first) begin
      // Single NAL unit packet: header plus the NAL header byte.
      if (first_len_ok && !first_is_frag) begin
        load_burst  = 1'b1;
        load_marker = 1'b1;
        load_pos    = POS_FIRST;
        load_end    = POS_FU_IND;
        size_next   = RTP_HDR_BYTES + nal.nal_length[15:0];
        final_next  = 1'b1;
      end
    end else if (!drop_unit && bytes_remaining != 24'd0) begin
      load_burst = 1'b1;
      if (!fragment_mode) begin
        seg_last = bytes_remaining == 24'd1;
      end else begin
        // A fragment opens when the previous one is used up.
        if (fragment_left == 16'd0) begin
          load_frag     = 1'b1;
          load_marker   = frag_end;
          load_pos      = POS_FIRST;
          size_next     = FU_PKT_OVERHEAD + frag_size;
          final_next    = frag_end;
          frag_left_eff = frag_size;
        end
        seg_last = frag_left_eff == 16'd1;
      end
    end
  end

  // Configuration and packetizer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_type      <= PAYLOAD_TYPE_RST;
      stream_ssrc       <= '0;
      single_max        <= MTU_BYTES_RST - RTP_HDR_BYTES;
      frag_max          <= MTU_BYTES_RST - FU_PKT_OVERHEAD;
      seq_counter       <= '0;
      saved_nal_header  <= '0;
      latched_timestamp <= '0;
      bytes_remaining   <= '0;
      fragment_left     <= '0;
      fragment_mode     <= 1'b0;
      first_fragment    <= 1'b1;
      drop_unit         <= 1'b0;
      pkt_size          <= '0;
      pkt_final         <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_PAYLOAD_TYPE: payload_type <= cfg_data[6:0];
          REG_MTU_BYTES: begin
            single_max <= (cfg_data[15:0] > RTP_HDR_BYTES) ?
                          cfg_data[15:0] - RTP_HDR_BYTES : 16'd0;
            frag_max   <= (cfg_data[15:0] > FU_MTU_MIN) ?
                          cfg_data[15:0] - FU_PKT_OVERHEAD : 16'd1;
          end
          REG_STREAM_SSRC: stream_ssrc <= cfg_data;
          REG_SEQ_START:   seq_counter <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (nal_fire) begin
        pkt_size  <= size_next;
        pkt_final <= final_next;
        if (nal.nal_first) begin
          saved_nal_header  <= nal.nal_byte;
          latched_timestamp <= nal.frame_timestamp;
          first_fragment    <= 1'b1;
          fragment_left     <= '0;
          drop_unit         <= ~first_len_ok;
          fragment_mode     <= first_len_ok & first_is_frag;
          bytes_remaining   <= first_len_ok ? nal.nal_length - 24'd1 : 24'd0;
        end else if (load_burst) begin
          bytes_remaining <= bytes_remaining - 24'd1;
          if (fragment_mode) begin
            fragment_left <= frag_left_eff - 16'd1;
            if (load_frag) begin
              first_fragment <= 1'b0;
            end
          end
          if (seg_last) begin
            seq_counter <= seq_counter + 16'd1;
          end
        end
      end
    end
  end

  // Burst stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_valid <= 1'b0;
      burst_pos   <= POS_FIRST;
    end else if (nal_fire && load_burst) begin
      burst_valid <= 1'b1;
      burst_pos   <= load_pos;
    end else if (burst_done) begin
      burst_valid <= 1'b0;
    end else if (advance) begin
      burst_pos <= burst_pos + 4'd1;
    end
  end

  // Burst stage payload, captured with the accepted byte.
  always_ff @(posedge clk) begin
    if (nal_fire && load_burst) begin
      burst_end    <= load_end;
      burst_frag   <= load_frag;
      burst_marker <= load_marker;
      burst_last   <= seg_last;
      burst_seq    <= seq_counter;
      burst_ts     <= nal.nal_first ? nal.frame_timestamp : latched_timestamp;
      burst_fu_ind <= (saved_nal_header & NAL_NRI_MASK) | FU_A_TYPE;
      burst_fu_hdr <= (first_fragment ? FU_START_BIT : 8'd0) |
                      (frag_end ? FU_END_BIT : 8'd0) |
                      (saved_nal_header & NAL_TYPE_MASK);
      burst_data   <= nal.nal_byte;
      burst_size   <= size_next;
      burst_final  <= final_next;
    end
  end

  // Byte at the current burst position.
  logic [7:0] burst_byte;

  always_comb begin
    case (burst_pos)
      4'd0:    burst_byte = RTP_VERSION_BYTE;
      4'd1:    burst_byte = {burst_marker, payload_type};
      4'd2:    burst_byte = burst_seq[15:8];
      4'd3:    burst_byte = burst_seq[7:0];
      4'd4:    burst_byte = burst_ts[31:24];
      4'd5:    burst_byte = burst_ts[23:16];
      4'd6:    burst_byte = burst_ts[15:8];
      4'd7:    burst_byte = burst_ts[7:0];
      4'd8:    burst_byte = stream_ssrc[31:24];
      4'd9:    burst_byte = stream_ssrc[23:16];
      4'd10:   burst_byte = stream_ssrc[15:8];
      4'd11:   burst_byte = stream_ssrc[7:0];
      4'd12:   burst_byte = burst_frag ? burst_fu_ind : burst_data;
      4'd13:   burst_byte = burst_fu_hdr;
      default: burst_byte = burst_data;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_valid <= 1'b0;
    end else if (advance) begin
      pkt_valid <= 1'b1;
    end else if (pkt_ready) begin
      pkt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pkt.out_byte     <= burst_byte;
      pkt.packet_first <= burst_pos == POS_FIRST;
      pkt.packet_last  <= (burst_pos == burst_end) & burst_last;
      pkt.packet_bytes <= burst_size;
      pkt.nal_done     <= burst_final;
      pkt.run_last     <= burst_pos == burst_end;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rtpnal_checker.sv -----
// Port-level checker for the RTP H.264 packetizer and its bind statement.
`default_nettype none

`include "rtp_h264_nal_packetizer_assert.svh"

module rtpnal_checker
  import rtpnal_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      pkt_valid,
  input wire logic      pkt_ready,
  input wire pkt_item_t pkt
);

  // A stalled output transaction holds its bytes.
  `RTPNAL_ASSERT_NEXT(a_pkt_hold, pkt_valid && !pkt_ready, pkt_valid && $stable(pkt), "pkt changed while stalled")

  // Every packet opens with the RTP version byte.
  `RTPNAL_ASSERT_NOW(a_first_version, pkt_valid && pkt.packet_first, pkt.out_byte == RTP_VERSION_BYTE, "packet does not open with version byte")

  // The last byte of a packet is always the last result of its input byte.
  `RTPNAL_ASSERT_NOW(a_last_ends_run, pkt_valid && pkt.packet_last, pkt.run_last, "packet end inside a header burst")

  // A header byte never closes the results of an input byte.
  `RTPNAL_ASSERT_NOW(a_first_not_run_end, pkt_valid && pkt.packet_first, !pkt.run_last && !pkt.packet_last, "header burst cut short")

endmodule

bind rtp_h264_nal_packetizer rtpnal_checker u_rtpnal_checker (
  .clk       (clk),
  .rst       (rst),
  .pkt_valid (pkt_valid),
  .pkt_ready (pkt_ready),
  .pkt       (pkt)
);

`default_nettype wire
